// ===== hw/rtl/pfpc_pkg.sv =====
package pfpc_pkg;

  localparam int FIFO_DEPTH = 32768;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam int RATE_W  = 18;
  localparam int PHASE_W = RATE_W + 1;
  localparam int THR_W   = 15;
  localparam int MIX_W   = 24;
  localparam int SMP_W   = 16;
  localparam int PROD_W  = SMP_W + 5;
  localparam int QUOT_W  = SMP_W + 1;

  localparam logic [RATE_W-1:0] RATE_RESET   = 18'd55466;
  localparam logic [THR_W-1:0]  THR_RESET    = 15'd128;
  localparam logic [THR_W-1:0]  THR_MAX      = 15'h7ffc;
  localparam logic [7:0]        FORMAT_RESET = 8'h32;
  localparam logic [3:0]        VOLUME_RESET = 4'd15;
  localparam logic [2:0]        VOL_CMD      = 3'b101;

  // x/15 as (x * ceil(2^23/15)) >> 23, exact for x below 2^20
  localparam int               VOL_FULL    = 15;
  localparam int               RECIP_SHIFT = 23;
  localparam int               RECIP_W     = 20;
  localparam logic [RECIP_W-1:0] RECIP_MUL =
      RECIP_W'((1 << RECIP_SHIFT) / VOL_FULL + 1);

  localparam logic [15:0] PHASE_INC [8] = '{
    16'(352800 / 8), 16'(264600 / 8), 16'(176400 / 8), 16'(132300 / 8),
    16'(88200 / 8),  16'(66150 / 8),  16'(44010 / 8),  16'(33075 / 8)
  };

  // bus ports
  localparam logic [2:0] PORT_CLK  = 3'd2;
  localparam logic [2:0] PORT_FIFO = 3'd3;
  localparam logic [2:0] PORT_FMT  = 3'd4;
  localparam logic [2:0] PORT_DATA = 3'd5;

  // fifo control bits
  localparam int FC_ENABLE = 7;
  localparam int FC_THR_EN = 5;
  localparam int FC_IRQ    = 4;
  localparam int FC_CLEAR  = 3;

  // frame formats
  localparam logic [2:0] FMT_WIDE_R   = 3'd1;
  localparam logic [2:0] FMT_WIDE_L   = 3'd2;
  localparam logic [2:0] FMT_WIDE_ST  = 3'd3;
  localparam logic [2:0] FMT_NARROW_R = 3'd5;
  localparam logic [2:0] FMT_NARROW_L = 3'd6;
  localparam logic [2:0] FMT_NARROW_ST = 3'd7;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2
  } opcode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_PHASE,
    S_POP,
    S_FETCH,
    S_TAKE,
    S_FRAME,
    S_MUL,
    S_RECIP,
    S_DONE
  } state_t;

  function automatic logic [2:0] frame_size(input logic [2:0] fmt);
    case (fmt)
      3'd3:                    return 3'd4;
      3'd4, 3'd5, 3'd6:        return 3'd1;
      default:                 return 3'd2;
    endcase
  endfunction

endpackage

// ===== hw/rtl/pcm_fifo_playback_controller.sv =====
// channel | direction | handshake         | payload
// in      | to block  | in_valid/in_stall | opcode, port_index, write_data, clock_level, mixes
// out     | from block| out_valid/out_stall | read_data, out_left, out_right, pcm_irq
// cfg     | to block  | cfg_wr_en         | cfg_wr_data (output rate)
//
// Bus read or write, or a tick with playback off: S_EXEC, then S_DONE loads the result.
// Tick with playback on: S_EXEC, S_PHASE, then per frame popped S_POP, S_FETCH and S_TAKE per
// byte (memory read is registered) and S_FRAME, or S_POP alone on underflow; then S_MUL,
// S_RECIP, S_DONE. Frames per tick = overflows found in S_PHASE, set by output rate and phase step.
// rst_n is synchronous; the sample memory is not cleared and needs no sweep.
// A new word is taken only from idle; a result held by out_stall blocks the next result.
module pcm_fifo_playback_controller
  import pfpc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_opcode,
  input  logic [2:0]               in_port_index,
  input  logic [7:0]               in_write_data,
  input  logic                     in_clock_level,
  input  logic signed [MIX_W-1:0]  in_mix_left,
  input  logic signed [MIX_W-1:0]  in_mix_right,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [7:0]               out_read_data,
  output logic signed [SMP_W-1:0]  out_left,
  output logic signed [SMP_W-1:0]  out_right,
  output logic                     out_pcm_irq,
  input  logic                     cfg_wr_en,
  input  logic [RATE_W-1:0]        cfg_wr_data
);

  state_t state_r, state_nxt;

  // latched word
  logic [1:0]              op_r, op_nxt;
  logic [2:0]              port_r, port_nxt;
  logic [7:0]              data_r, data_nxt;
  logic                    clk_lvl_r, clk_lvl_nxt;
  logic signed [MIX_W-1:0] mix_l_r, mix_l_nxt, mix_rt_r, mix_rt_nxt;

  // architectural state
  logic [RATE_W-1:0]       rate_r;
  logic [PTR_W-1:0]        rp_r, rp_nxt, wp_r, wp_nxt;
  logic [CNT_W-1:0]        fill_r, fill_nxt;
  logic [THR_W-1:0]        thr_r, thr_nxt;
  logic [PHASE_W-1:0]      phase_r, phase_nxt;
  logic signed [SMP_W-1:0] last_l_r, last_l_nxt, last_rt_r, last_rt_nxt;
  logic                    irq_pending_r, irq_pending_nxt;
  logic                    irq_armed_r, irq_armed_nxt;
  logic [7:0]              fifo_control_r, fifo_control_nxt;
  logic [7:0]              format_r, format_nxt;
  logic [3:0]              vol_r, vol_nxt;

  // work registers
  logic [2:0]               cnt_r, cnt_nxt;
  logic [31:0]              frame_r, frame_nxt;
  logic signed [PROD_W-1:0] prod_l_r, prod_l_nxt, prod_rt_r, prod_rt_nxt;
  logic signed [QUOT_W-1:0] q_l_r, q_l_nxt, q_rt_r, q_rt_nxt;
  logic [7:0]               rd_r, rd_nxt;

  // result register
  logic                    out_valid_r, out_valid_nxt;
  logic [7:0]              out_rd_r, out_rd_nxt;
  logic signed [SMP_W-1:0] out_l_r, out_l_nxt, out_rt_r, out_rt_nxt;
  logic                    out_irq_r, out_irq_nxt;

  // sample memory
  logic [7:0] mem [FIFO_DEPTH];
  logic [7:0] mem_q_r;
  logic       mem_we;

  logic              in_accept;
  logic              out_free;
  logic [2:0]        fmt;
  logic [2:0]        n_bytes;
  logic              fifo_full;
  logic              fifo_short;
  logic [RATE_W-1:0] modulus;
  logic              irq_hit;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic signed [SMP_W-1:0] clip16(
    input logic signed [MIX_W-1:0]  mix,
    input logic signed [QUOT_W-1:0] q
  );
    logic signed [MIX_W:0] s;
    s = $signed({mix[MIX_W-1], mix}) + $signed({{(MIX_W-QUOT_W+1){q[QUOT_W-1]}}, q});
    if (s > $signed((MIX_W+1)'(32767))) return 16'sh7fff;
    if (s < -$signed((MIX_W+1)'(32768))) return 16'sh8000;
    return s[SMP_W-1:0];
  endfunction

  function automatic logic signed [QUOT_W-1:0] div15(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-1:0]          mag;
    logic [2*RECIP_W-1:0]       m;
    logic [QUOT_W-1:0]          q;
    mag = p[PROD_W-1] ? (~p + 1'b1) : p;
    m   = mag[RECIP_W-1:0] * RECIP_MUL;
    q   = m[RECIP_SHIFT +: QUOT_W];
    return p[PROD_W-1] ? $signed(~q + 1'b1) : $signed(q);
  endfunction

  assign in_accept  = in_valid && !in_stall;
  assign out_free   = !(out_valid_r && out_stall);
  assign fmt        = format_r[6:4];
  assign n_bytes    = frame_size(fmt);
  assign fifo_full  = (fill_r == CNT_W'(FIFO_DEPTH));
  assign fifo_short = (fill_r < CNT_W'(n_bytes));
  assign modulus    = (rate_r == '0) ? RATE_W'(1) : rate_r;
  assign irq_hit    = fifo_control_r[FC_THR_EN] && irq_armed_r &&
                      ((THR_W+2)'(fill_r) <= (THR_W+2)'(thr_r));

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_read_data = out_rd_r;
  assign out_left      = out_l_r;
  assign out_right     = out_rt_r;
  assign out_pcm_irq   = out_irq_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_accept) state_nxt = S_EXEC;
      S_EXEC: begin
        if (op_r == OP_TICK && fifo_control_r[FC_ENABLE]) state_nxt = S_PHASE;
        else state_nxt = S_DONE;
      end
      S_PHASE: state_nxt = (phase_r >= {1'b0, modulus}) ? S_POP : S_MUL;
      S_POP:   state_nxt = fifo_short ? S_PHASE : S_FETCH;
      S_FETCH: state_nxt = S_TAKE;
      S_TAKE:  state_nxt = (cnt_r == '0) ? S_FRAME : S_FETCH;
      S_FRAME: state_nxt = S_PHASE;
      S_MUL:   state_nxt = S_RECIP;
      S_RECIP: state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    op_nxt           = op_r;
    port_nxt         = port_r;
    data_nxt         = data_r;
    clk_lvl_nxt      = clk_lvl_r;
    mix_l_nxt        = mix_l_r;
    mix_rt_nxt       = mix_rt_r;
    rp_nxt           = rp_r;
    wp_nxt           = wp_r;
    fill_nxt         = fill_r;
    thr_nxt          = thr_r;
    phase_nxt        = phase_r;
    last_l_nxt       = last_l_r;
    last_rt_nxt      = last_rt_r;
    irq_pending_nxt  = irq_pending_r;
    irq_armed_nxt    = irq_armed_r;
    fifo_control_nxt = fifo_control_r;
    format_nxt       = format_r;
    vol_nxt          = vol_r;
    cnt_nxt          = cnt_r;
    frame_nxt        = frame_r;
    prod_l_nxt       = prod_l_r;
    prod_rt_nxt      = prod_rt_r;
    q_l_nxt          = q_l_r;
    q_rt_nxt         = q_rt_r;
    rd_nxt           = rd_r;
    mem_we           = 1'b0;
    out_valid_nxt    = out_valid_r && out_stall;
    out_rd_nxt       = out_rd_r;
    out_l_nxt        = out_l_r;
    out_rt_nxt       = out_rt_r;
    out_irq_nxt      = out_irq_r;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          op_nxt      = in_opcode;
          port_nxt    = in_port_index;
          data_nxt    = in_write_data;
          clk_lvl_nxt = in_clock_level;
          mix_l_nxt   = in_mix_left;
          mix_rt_nxt  = in_mix_right;
        end
      end
      S_EXEC: begin
        rd_nxt   = '0;
        q_l_nxt  = '0;
        q_rt_nxt = '0;
        case (op_r)
          OP_READ: begin
            case (port_r)
              PORT_CLK:  rd_nxt = {fifo_full, !fifo_full && fifo_short, 5'b0, clk_lvl_r};
              PORT_FIFO: rd_nxt = {fifo_control_r[7:5], irq_pending_r, fifo_control_r[3:0]};
              PORT_FMT:  rd_nxt = format_r;
              default:   rd_nxt = '0;
            endcase
          end
          OP_WRITE: begin
            case (port_r)
              PORT_CLK: begin
                if (data_r[7:5] == VOL_CMD) vol_nxt = ~data_r[3:0];
              end
              PORT_FIFO: begin
                if (data_r[FC_CLEAR] && !fifo_control_r[FC_CLEAR]) begin
                  rp_nxt        = '0;
                  wp_nxt        = '0;
                  fill_nxt      = '0;
                  phase_nxt     = '0;
                  last_l_nxt    = '0;
                  last_rt_nxt   = '0;
                  irq_armed_nxt = 1'b0;
                end
                if (!data_r[FC_IRQ]) irq_pending_nxt = 1'b0;
                fifo_control_nxt = data_r & 8'hef;
              end
              PORT_FMT: begin
                if (fifo_control_r[FC_THR_EN]) begin
                  thr_nxt = (data_r == 8'hff) ? THR_MAX
                                              : THR_W'((16'(data_r) + 16'd1) << 7);
                end else if (data_r[3:0] != 4'hf) begin
                  format_nxt = data_r;
                end
              end
              PORT_DATA: begin
                // drop the byte when full
                if (!fifo_full) begin
                  mem_we        = 1'b1;
                  wp_nxt        = ptr_inc(wp_r);
                  fill_nxt      = fill_r + 1'b1;
                  irq_armed_nxt = 1'b1;
                end
              end
              default: ;
            endcase
          end
          OP_TICK: begin
            if (fifo_control_r[FC_ENABLE])
              phase_nxt = phase_r + PHASE_W'(PHASE_INC[fifo_control_r[2:0]]);
          end
          default: ;
        endcase
      end
      S_PHASE: begin
        if (phase_r >= {1'b0, modulus}) phase_nxt = phase_r - {1'b0, modulus};
      end
      S_POP: begin
        if (fifo_short) begin
          last_l_nxt  = '0;
          last_rt_nxt = '0;
          if (irq_hit) begin
            irq_armed_nxt   = 1'b0;
            irq_pending_nxt = 1'b1;
          end
        end else begin
          cnt_nxt = n_bytes;
        end
      end
      S_FETCH: begin
        rp_nxt   = ptr_inc(rp_r);
        fill_nxt = fill_r - 1'b1;
        cnt_nxt  = cnt_r - 1'b1;
      end
      S_TAKE: begin
        frame_nxt = {frame_r[23:0], mem_q_r};
      end
      S_FRAME: begin
        last_l_nxt  = '0;
        last_rt_nxt = '0;
        case (fmt)
          FMT_WIDE_R:    last_rt_nxt = frame_r[15:0];
          FMT_WIDE_L:    last_l_nxt  = frame_r[15:0];
          FMT_WIDE_ST: begin
            last_l_nxt  = frame_r[31:16];
            last_rt_nxt = frame_r[15:0];
          end
          FMT_NARROW_R:  last_rt_nxt = {frame_r[7:0], 8'h00};
          FMT_NARROW_L:  last_l_nxt  = {frame_r[7:0], 8'h00};
          FMT_NARROW_ST: begin
            last_l_nxt  = {frame_r[15:8], 8'h00};
            last_rt_nxt = {frame_r[7:0], 8'h00};
          end
          default: ;
        endcase
        if (irq_hit) begin
          irq_armed_nxt   = 1'b0;
          irq_pending_nxt = 1'b1;
        end
      end
      S_MUL: begin
        prod_l_nxt  = $signed({{(PROD_W-SMP_W){last_l_r[SMP_W-1]}}, last_l_r}) *
                      $signed({{(PROD_W-4){1'b0}}, vol_r});
        prod_rt_nxt = $signed({{(PROD_W-SMP_W){last_rt_r[SMP_W-1]}}, last_rt_r}) *
                      $signed({{(PROD_W-4){1'b0}}, vol_r});
      end
      S_RECIP: begin
        q_l_nxt  = div15(prod_l_r);
        q_rt_nxt = div15(prod_rt_r);
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_rd_nxt    = rd_r;
          out_irq_nxt   = irq_pending_r;
          if (op_r == OP_TICK) begin
            out_l_nxt  = clip16(mix_l_r, q_l_r);
            out_rt_nxt = clip16(mix_rt_r, q_rt_r);
          end else begin
            out_l_nxt  = '0;
            out_rt_nxt = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      rate_r         <= RATE_RESET;
      rp_r           <= '0;
      wp_r           <= '0;
      fill_r         <= '0;
      thr_r          <= THR_RESET;
      phase_r        <= '0;
      last_l_r       <= '0;
      last_rt_r      <= '0;
      irq_pending_r  <= 1'b0;
      irq_armed_r    <= 1'b0;
      fifo_control_r <= '0;
      format_r       <= FORMAT_RESET;
      vol_r          <= VOLUME_RESET;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      if (cfg_wr_en) rate_r <= cfg_wr_data;
      rp_r           <= rp_nxt;
      wp_r           <= wp_nxt;
      fill_r         <= fill_nxt;
      thr_r          <= thr_nxt;
      phase_r        <= phase_nxt;
      last_l_r       <= last_l_nxt;
      last_rt_r      <= last_rt_nxt;
      irq_pending_r  <= irq_pending_nxt;
      irq_armed_r    <= irq_armed_nxt;
      fifo_control_r <= fifo_control_nxt;
      format_r       <= format_nxt;
      vol_r          <= vol_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    port_r    <= port_nxt;
    data_r    <= data_nxt;
    clk_lvl_r <= clk_lvl_nxt;
    mix_l_r   <= mix_l_nxt;
    mix_rt_r  <= mix_rt_nxt;
    cnt_r     <= cnt_nxt;
    frame_r   <= frame_nxt;
    prod_l_r  <= prod_l_nxt;
    prod_rt_r <= prod_rt_nxt;
    q_l_r     <= q_l_nxt;
    q_rt_r    <= q_rt_nxt;
    rd_r      <= rd_nxt;
    out_rd_r  <= out_rd_nxt;
    out_l_r   <= out_l_nxt;
    out_rt_r  <= out_rt_nxt;
    out_irq_r <= out_irq_nxt;
  end

  // pushes (S_EXEC) and pops (S_FETCH) never fall in the same state, so the read port needs no forwarding
  always_ff @(posedge clk) begin
    if (mem_we) mem[wp_r] <= data_r;
    mem_q_r <= mem[rp_r];
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(FIFO_DEPTH))
    else $error("fill count above depth");

  a_fetch_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FETCH |-> fill_r != '0)
    else $error("pop from empty fifo");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result loaded outside done state");

  a_irq_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(irq_pending_r) |-> $past(fifo_control_r[FC_THR_EN]) && $past(irq_armed_r))
    else $error("interrupt raised without threshold enable and arm");

endmodule
